// ===== design/rsd_pkg.sv =====
// Shared types, constants and helper functions of the rANS symbol decoder.
`default_nettype none

package rsd_pkg;

    // Build-time sizes of the decoder.
    localparam int CONTEXTS      = 256;
    localparam int MAX_LOG_RANGE = 12;
    localparam int TOP_LOG       = 23;
    localparam int MIN_LOG_RANGE = 8;

    // Derived widths and memory depths.
    localparam int CTX_W        = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int SLOT_W       = MAX_LOG_RANGE;
    localparam int FREQ_W       = MAX_LOG_RANGE;
    localparam int CUM_W        = 12;
    localparam int LR_W         = 4;
    localparam int HI_W         = 32 - MIN_LOG_RANGE;
    localparam int SYM_ENTRY_W  = CUM_W + FREQ_W;
    localparam int SYM_DEPTH    = CONTEXTS * 256;
    localparam int SLOT_DEPTH   = CONTEXTS * (1 << MAX_LOG_RANGE);
    localparam int SYM_AW       = $clog2(SYM_DEPTH);
    localparam int SLOT_AW      = $clog2(SLOT_DEPTH);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Port widths.
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 16;

    // Host command codes.
    localparam logic [2:0] CMD_LOAD_SYM  = 3'd0;
    localparam logic [2:0] CMD_LOAD_SLOT = 3'd1;
    localparam logic [2:0] CMD_START     = 3'd2;
    localparam logic [2:0] CMD_DECODE    = 3'd3;
    localparam logic [2:0] CMD_BYTE      = 3'd4;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_NO_BYTE   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ORDER     = 1'b0;
    localparam logic CFG_LOG_RANGE = 1'b1;

    // Operation classes that the front hands to the back.
    typedef enum logic [2:0] {
        OP_LOAD_SYM,
        OP_LOAD_SLOT,
        OP_START,
        OP_DECODE,
        OP_BYTE,
        OP_NOP
    } op_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SLOT,
        BK_SYM,
        BK_MUL
    } bk_state_t;

    // Effective configuration seen by front and back.
    typedef struct packed {
        logic                     order;
        logic [LR_W-1:0]          lr;
        logic [MAX_LOG_RANGE-1:0] mask;
    } cfg_t;

    // One classified word waiting in the queue.
    typedef struct packed {
        op_t               op;
        logic [CTX_W-1:0]  ctx;
        logic [7:0]        sym;
        logic [SLOT_W-1:0] slot;
        logic [CUM_W-1:0]  cum;
        logic [FREQ_W-1:0] freq;
        logic [31:0]       init_state;
        logic [7:0]        byte_val;
    } item_t;

    // Previous symbol to context index, reduced modulo the context count.
    function automatic logic [CTX_W-1:0] ctx_of_prev(logic [7:0] prev);
        logic [CTX_W-1:0] c;
        c = '0;
        for (int i = 0; i < 256; i++) begin
            if (prev == 8'(i)) c = CTX_W'(i % CONTEXTS);
        end
        return c;
    endfunction

    // Clamp the programmed log range into the supported window.
    function automatic logic [LR_W-1:0] eff_log_range(logic [LR_W-1:0] lr);
        logic [LR_W-1:0] r;
        r = lr;
        if (r < LR_W'(MIN_LOG_RANGE)) r = LR_W'(MIN_LOG_RANGE);
        if (r > LR_W'(MAX_LOG_RANGE)) r = LR_W'(MAX_LOG_RANGE);
        return r;
    endfunction

    // Low-bit mask of the given log range.
    function automatic logic [MAX_LOG_RANGE-1:0] range_mask(logic [LR_W-1:0] lr);
        logic [MAX_LOG_RANGE-1:0] m;
        for (int i = 0; i < MAX_LOG_RANGE; i++) begin
            m[i] = (i < int'(lr));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/rans_symbol_decoder.sv =====
// Top level of the rANS symbol decoder: configuration, front, queue and back.
//
//   Channel  Direction  Words carried
//   s_       in         one host command (load symbol, load slot, start, decode, byte)
//   m_       out        one result per command: symbol, need flag, status
//   cfg_     in         register writes: index 0 order, index 1 log range
//
// Loads, chunk starts, bytes and unknown codes complete in the back end's idle state.
// A decode steps through slot map read, symbol table read, multiply and state update;
// the symbol table read is addressed by the slot map read data, so the two are chained.
// Reset sets order 0 and log range 12, clears the coder state and the handshakes;
// tables hold nothing until loaded.
// A two-word queue lets the input keep accepting while the result register is stalled.
`default_nettype none

module rans_symbol_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // command[2:0], context_req[10:3], symbol[18:11], slot[30:19], cum_freq[42:31],
    // freq[55:43], init_state[87:56], byte_in[95:88]
    input  wire logic [rsd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // symbol_out[7:0], need_byte[8], status[10:9], zeros above
    output logic      [rsd_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [rsd_pkg::LR_W-1:0]      cfg_wdata
);
    import rsd_pkg::*;

    logic            order_reg, order_next;
    logic [LR_W-1:0] log_range_reg, log_range_next;
    cfg_t            cfg;
    logic            queue_full;
    logic            push;
    item_t           push_item;
    item_t           head_item;
    logic            head_valid;
    logic            pop;

    // Configuration registers.
    always_comb begin
        order_next     = order_reg;
        log_range_next = log_range_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ORDER:     order_next = cfg_wdata[0];
                CFG_LOG_RANGE: log_range_next = cfg_wdata;
                default:       order_next = order_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg     <= 1'b0;
            log_range_reg <= LR_W'(12);
        end else begin
            order_reg     <= order_next;
            log_range_reg <= log_range_next;
        end
    end

    // Effective settings shared by both sides.
    always_comb begin
        cfg.order = order_reg;
        cfg.lr    = eff_log_range(log_range_reg);
        cfg.mask  = range_mask(cfg.lr);
    end

    rsd_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .item       (push_item)
    );

    rsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_item  (head_item),
        .head_valid (head_valid)
    );

    rsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (head_valid),
        .item       (head_item),
        .item_pop   (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// ===== design/rsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/rsd_queue.sv =====
// Short first-in first-out queue of classified words between front and back.
`default_nettype none

module rsd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire rsd_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output rsd_pkg::item_t      head_item,
    output logic                head_valid
);
    import rsd_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage entries.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/rsd_front.sv =====
// Input side: accepts command words and classifies them for the back end.
`default_nettype none

module rsd_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rsd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire rsd_pkg::cfg_t                 cfg,
    input  wire logic                          queue_full,
    output logic                               push,
    output rsd_pkg::item_t                     item
);
    import rsd_pkg::*;

    logic [2:0]  command;
    logic [7:0]  context_req;
    logic [7:0]  symbol;
    logic [11:0] slot;
    logic [11:0] cum_freq;
    logic [12:0] freq;
    logic        ctx_ok;

    // Unpack the word.
    assign command     = s_tdata[2:0];
    assign context_req = s_tdata[10:3];
    assign symbol      = s_tdata[18:11];
    assign slot        = s_tdata[30:19];
    assign cum_freq    = s_tdata[42:31];
    assign freq        = s_tdata[55:43];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Loads into a context beyond the table count are dropped.
    assign ctx_ok = ({1'b0, context_req} < 9'(CONTEXTS));

    // Classify and precompute the load fields.
    always_comb begin
        item.ctx        = CTX_W'(context_req);
        item.sym        = symbol;
        item.slot       = SLOT_W'(slot) & cfg.mask;
        item.cum        = cum_freq;
        item.init_state = s_tdata[87:56];
        item.byte_val   = s_tdata[95:88];
        // Frequency is clamped to one below the scale.
        if (16'(freq) > 16'(cfg.mask)) begin
            item.freq = cfg.mask;
        end else begin
            item.freq = FREQ_W'(freq);
        end
        case (command)
            CMD_LOAD_SYM:  item.op = ctx_ok ? OP_LOAD_SYM : OP_NOP;
            CMD_LOAD_SLOT: item.op = ctx_ok ? OP_LOAD_SLOT : OP_NOP;
            CMD_START:     item.op = OP_START;
            CMD_DECODE:    item.op = OP_DECODE;
            CMD_BYTE:      item.op = OP_BYTE;
            default:       item.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/rsd_back.sv =====
// Execution side: table memories, coder state, decode sequencer and result register.
`default_nettype none

module rsd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rsd_pkg::cfg_t                 cfg,
    input  wire logic                          item_valid,
    input  wire rsd_pkg::item_t                item,
    output logic                               item_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [rsd_pkg::M_TDATA_W-1:0] m_tdata
);
    import rsd_pkg::*;

    bk_state_t         st_reg, st_next;
    logic [31:0]       coder_reg, coder_next;
    logic [7:0]        prev_reg, prev_next;
    logic              active_reg, active_next;
    logic [CTX_W-1:0]  dec_ctx_reg, dec_ctx_next;
    logic [SLOT_W-1:0] dec_low_reg, dec_low_next;
    logic [HI_W-1:0]   dec_hi_reg, dec_hi_next;
    logic [7:0]        cur_sym_reg, cur_sym_next;
    logic [31:0]       prod_reg, prod_next;
    logic [CUM_W-1:0]  cum_reg, cum_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_sym_reg, out_sym_next;
    logic              out_need_reg, out_need_next;
    logic [1:0]        out_status_reg, out_status_next;

    logic                   out_free;
    logic                   wants_byte;
    logic                   emit;
    logic [7:0]             emit_sym;
    logic [1:0]             emit_status;
    logic [CTX_W-1:0]       dec_ctx;
    logic [SLOT_W-1:0]      dec_low;

    logic                   sym_we, sym_re;
    logic [SYM_AW-1:0]      sym_waddr, sym_raddr;
    logic [SYM_ENTRY_W-1:0] sym_wdata, sym_rdata;
    logic                   slot_we, slot_re;
    logic [SLOT_AW-1:0]     slot_waddr, slot_raddr;
    logic [7:0]             slot_rdata;

    // Symbol table: cumulative start over clamped frequency per context and symbol.
    rsd_ram #(
        .WIDTH (SYM_ENTRY_W),
        .DEPTH (SYM_DEPTH)
    ) u_sym_table (
        .aclk    (aclk),
        .wr_en   (sym_we),
        .wr_addr (sym_waddr),
        .wr_data (sym_wdata),
        .rd_en   (sym_re),
        .rd_addr (sym_raddr),
        .rd_data (sym_rdata)
    );

    // Slot map: frequency slot to symbol per context.
    rsd_ram #(
        .WIDTH (8),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_map (
        .aclk    (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (item.sym),
        .rd_en   (slot_re),
        .rd_addr (slot_raddr),
        .rd_data (slot_rdata)
    );

    assign out_free   = !out_valid_reg || m_tready;
    assign wants_byte = active_reg && (coder_reg[31:TOP_LOG] == '0);
    assign dec_ctx    = cfg.order ? ctx_of_prev(prev_reg) : '0;
    assign dec_low    = coder_reg[SLOT_W-1:0] & cfg.mask;

    assign sym_waddr  = SYM_AW'({item.ctx, item.sym});
    assign sym_wdata  = {item.cum, item.freq};
    assign slot_waddr = SLOT_AW'({item.ctx, item.slot});

    // Sequencer: one word per cycle unless stalled; decodes: slot, table, multiply.
    always_comb begin
        st_next      = st_reg;
        coder_next   = coder_reg;
        prev_next    = prev_reg;
        active_next  = active_reg;
        dec_ctx_next = dec_ctx_reg;
        dec_low_next = dec_low_reg;
        dec_hi_next  = dec_hi_reg;
        cur_sym_next = cur_sym_reg;
        prod_next    = prod_reg;
        cum_next     = cum_reg;
        item_pop     = 1'b0;
        emit         = 1'b0;
        emit_sym     = 8'd0;
        emit_status  = STATUS_OK;
        sym_we       = 1'b0;
        sym_re       = 1'b0;
        sym_raddr    = SYM_AW'({dec_ctx_reg, slot_rdata});
        slot_we      = 1'b0;
        slot_re      = 1'b0;
        slot_raddr   = SLOT_AW'({dec_ctx, dec_low});
        case (st_reg)
            BK_IDLE: begin
                if (item_valid && out_free) begin
                    item_pop = 1'b1;
                    case (item.op)
                        OP_LOAD_SYM: begin
                            sym_we = 1'b1;
                            emit   = 1'b1;
                        end
                        OP_LOAD_SLOT: begin
                            slot_we = 1'b1;
                            emit    = 1'b1;
                        end
                        OP_START: begin
                            coder_next  = item.init_state;
                            prev_next   = 8'd0;
                            active_next = 1'b1;
                            emit        = 1'b1;
                        end
                        OP_DECODE: begin
                            if (!active_reg || wants_byte) begin
                                emit        = 1'b1;
                                emit_status = STATUS_NOT_READY;
                            end else begin
                                slot_re      = 1'b1;
                                dec_ctx_next = dec_ctx;
                                dec_low_next = dec_low;
                                dec_hi_next  = HI_W'(coder_reg >> cfg.lr);
                                st_next      = BK_SLOT;
                            end
                        end
                        OP_BYTE: begin
                            emit = 1'b1;
                            if (wants_byte) begin
                                coder_next = {coder_reg[23:0], item.byte_val};
                            end else begin
                                emit_status = STATUS_NO_BYTE;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            BK_SLOT: begin
                // Slot map data is in; look up the symbol's entry.
                sym_re       = 1'b1;
                cur_sym_next = slot_rdata;
                st_next      = BK_SYM;
            end
            BK_SYM: begin
                // Scale the upper state bits by the symbol frequency.
                prod_next = 32'(32'(sym_rdata[FREQ_W-1:0]) * 32'(dec_hi_reg));
                cum_next  = sym_rdata[SYM_ENTRY_W-1:FREQ_W];
                st_next   = BK_MUL;
            end
            BK_MUL: begin
                if (out_free) begin
                    coder_next = prod_reg + 32'(dec_low_reg) - 32'(cum_reg);
                    prev_next  = cur_sym_reg;
                    emit       = 1'b1;
                    emit_sym   = cur_sym_reg;
                    st_next    = BK_IDLE;
                end
            end
            default: begin
                st_next = BK_IDLE;
            end
        endcase
    end

    // Result register, loaded with the state as it stands after the word.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_need_next   = out_need_reg;
        out_status_next = out_status_reg;
        if (emit) begin
            out_valid_next  = 1'b1;
            out_sym_next    = emit_sym;
            out_need_next   = active_next && (coder_next[31:TOP_LOG] == '0);
            out_status_next = emit_status;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= BK_IDLE;
            coder_reg     <= '0;
            prev_reg      <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            coder_reg     <= coder_next;
            prev_reg      <= prev_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        dec_ctx_reg    <= dec_ctx_next;
        dec_low_reg    <= dec_low_next;
        dec_hi_reg     <= dec_hi_next;
        cur_sym_reg    <= cur_sym_next;
        prod_reg       <= prod_next;
        cum_reg        <= cum_next;
        out_sym_reg    <= out_sym_next;
        out_need_reg   <= out_need_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_need_reg, out_sym_reg};

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the rANS symbol decoder: a directed table, then randomized chunks.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsd_pkg::*;

    // Run length and pacing.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_WORDS  = 92;

    // Command codes with no meaning; the decoder must ignore them.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // The state asks for bytes while it is below this floor.
    localparam logic [31:0] BYTE_FLOOR = 32'(1) << TOP_LOG;
    localparam int          CTX_SLOTS  = 1 << MAX_LOG_RANGE;

    // One command word, laid out exactly as s_tdata (last field in the lowest bits).
    typedef struct packed {
        logic [7:0]  byte_in;
        logic [31:0] init_state;
        logic [12:0] freq;
        logic [11:0] cum_freq;
        logic [11:0] slot;
        logic [7:0]  symbol;
        logic [7:0]  context_req;
        logic [2:0]  command;
    } cmd_word_t;

    // One result word, laid out as the low bits of m_tdata.
    typedef struct packed {
        logic [1:0] status;
        logic       need_byte;
        logic [7:0] symbol_out;
    } result_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // A directed step. A configuration row carries order in context_req and log range in symbol.
    typedef struct {
        row_kind_t   kind;
        logic [2:0]  command;
        logic [7:0]  context_req;
        logic [7:0]  symbol;
        logic [11:0] slot;
        logic [11:0] cum_freq;
        logic [12:0] freq;
        logic [31:0] init_state;
        logic [7:0]  byte_in;
        bit          typed;
        logic [7:0]  symbol_out;
        logic        need_byte;
        logic [1:0]  status;
    } dir_row_t;

    // One randomized phase: configuration, idling and pressure.
    typedef struct {
        logic       order;
        logic [3:0] lr;
        int         send_pct;
        int         recv_pct;
        bit         pause_mid;
        bit         hold_mid;
    } phase_t;

    // kind, command, ctx, symbol, slot, cum, freq, init_state, byte, typed, sym_out, need, status
    dir_row_t dir_rows [27] = '{
        '{ROW_WORD, CMD_DECODE,    0,     0,     0,      0,      1,    0,   0,     1, 0, 0,
          STATUS_NOT_READY},
        '{ROW_WORD, CMD_BYTE,      0,     0,     0,      0,      1,    0,   8'hA5, 1, 0, 0,
          STATUS_NO_BYTE},
        '{ROW_WORD, CMD_UNUSED_LO, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 4096, 32'hFFFF_FFFF, 8'hFF,
          1, 0, 0, STATUS_OK},
        '{ROW_WORD, CMD_UNUSED_HI, 0,     0,     0,      0,      1,    0,   0,     1, 0, 0,
          STATUS_OK},
        // Frequency above the scale is clamped on load.
        '{ROW_WORD, CMD_LOAD_SYM,  0,     8'h5A, 0,      0,      4096, 0,   0,     1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_LOAD_SLOT, 0,     8'h5A, 12'hFFF, 0,     1,    0,   0,     1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_LOAD_SYM,  8'hFF, 8'hFF, 0,      12'hFFF, 1,   0,   0,     1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_LOAD_SLOT, 8'hFF, 8'hFF, 0,      0,      1,    0,   0,     1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_START,     0,     0,     0,      0,      1, 32'hFFFF_FFFF, 0, 1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_DECODE,    0,     0,     0,      0,      1,    0,   0,     0, 0, 0,
          STATUS_OK},
        // A zero state needs bytes at once; decode is refused until they come.
        '{ROW_WORD, CMD_START,     0,     0,     0,      0,      1,    0,   0,     1, 0, 1,
          STATUS_OK},
        '{ROW_WORD, CMD_DECODE,    0,     0,     0,      0,      1,    0,   0,     1, 0, 1,
          STATUS_NOT_READY},
        '{ROW_WORD, CMD_BYTE,      0,     0,     0,      0,      1,    0,   8'h00, 1, 0, 1,
          STATUS_OK},
        '{ROW_WORD, CMD_BYTE,      0,     0,     0,      0,      1,    0,   8'hFF, 1, 0, 1,
          STATUS_OK},
        '{ROW_WORD, CMD_BYTE,      0,     0,     0,      0,      1,    0,   8'hFF, 1, 0, 1,
          STATUS_OK},
        '{ROW_WORD, CMD_BYTE,      0,     0,     0,      0,      1,    0,   8'hFF, 1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_BYTE,      0,     0,     0,      0,      1,    0,   8'h3C, 1, 0, 0,
          STATUS_NO_BYTE},
        '{ROW_WORD, CMD_DECODE,    0,     0,     0,      0,      1,    0,   0,     0, 0, 0,
          STATUS_OK},
        // Order 1 with a log range above the cap.
        '{ROW_CFG,  CMD_START,     1,     15,    0,      0,      1,    0,   0,     0, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_START,     0,     0,     0,      0,      1, 32'hFFFF_FFFF, 0, 1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_DECODE,    0,     0,     0,      0,      1,    0,   0,     0, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_LOAD_SLOT, 8'h5A, 0,     0,      0,      1,    0,   0,     1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_LOAD_SYM,  8'h5A, 0,     0,      0,      1,    0,   0,     1, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_DECODE,    0,     0,     0,      0,      1,    0,   0,     0, 0, 0,
          STATUS_OK},
        // Order 0 with a log range below the floor; the slot index is masked to 8 bits.
        '{ROW_CFG,  CMD_START,     0,     3,     0,      0,      1,    0,   0,     0, 0, 0,
          STATUS_OK},
        '{ROW_WORD, CMD_LOAD_SLOT, 0,     8'h11, 12'hFFF, 0,     1,    0,   0,     1, 0, 1,
          STATUS_OK},
        '{ROW_WORD, CMD_BYTE,      0,     0,     0,      0,      1,    0,   8'h5C, 0, 0, 0,
          STATUS_OK}
    };

    phase_t phases [6] = '{
        '{1'b0, 4'd12, 38, 88, 1'b0, 1'b0},
        '{1'b1, 4'd8,  38, 88, 1'b1, 1'b0},
        '{1'b1, 4'd15, 88, 38, 1'b0, 1'b0},
        '{1'b0, 4'd0,  88, 38, 1'b0, 1'b0},
        '{1'b1, 4'd12, 0,  0,  1'b0, 1'b1},
        '{1'b0, 4'd10, 0,  0,  1'b1, 1'b0}
    };

    // Block ports.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_addr  = CFG_ORDER;
    logic [LR_W-1:0]      cfg_wdata = '0;

    // Decoder state as the testbench tracks it.
    logic [31:0] dec_state = '0;
    logic [7:0]  dec_prev  = '0;
    bit          dec_live  = 1'b0;
    logic        dec_order = 1'b0;
    logic [3:0]  dec_lr    = 4'd12;
    logic [11:0] cum_of      [int];
    logic [11:0] freq_of     [int];
    logic [7:0]  sym_at_slot [int];

    // Result words still to come from the decoder, oldest first.
    result_t rans_out_q [$];

    int send_idle_pct = 38;
    int recv_idle_pct = 88;
    int words_sent    = 0;
    int mismatches    = 0;
    int cycles        = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    rans_symbol_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Log range in use: the programmed value held inside 8..MAX_LOG_RANGE.
    function automatic int live_log_range();
        if (dec_lr < 4'd8) return 8;
        if (int'(dec_lr) > MAX_LOG_RANGE) return MAX_LOG_RANGE;
        return int'(dec_lr);
    endfunction

    function automatic logic [31:0] live_mask();
        return (32'(1) << live_log_range()) - 32'd1;
    endfunction

    // Apply one command word to the tracked state and return the word it must produce.
    function automatic result_t rans_advance(cmd_word_t w);
        result_t     r;
        int          lr;
        int          ctx;
        logic [31:0] mask;
        logic [31:0] low;
        logic [31:0] f;
        logic [31:0] c;
        logic [7:0]  s;
        r    = '0;
        lr   = live_log_range();
        mask = live_mask();
        case (w.command)
            CMD_LOAD_SYM: begin
                cum_of[int'(w.context_req) * 256 + int'(w.symbol)] = w.cum_freq;
                freq_of[int'(w.context_req) * 256 + int'(w.symbol)] =
                    (32'(w.freq) > mask) ? mask[11:0] : w.freq[11:0];
            end
            CMD_LOAD_SLOT: begin
                sym_at_slot[int'(w.context_req) * CTX_SLOTS + int'(32'(w.slot) & mask)] =
                    w.symbol;
            end
            CMD_START: begin
                dec_state = w.init_state;
                dec_prev  = '0;
                dec_live  = 1'b1;
            end
            CMD_DECODE: begin
                if (!dec_live || dec_state < BYTE_FLOOR) begin
                    r.status = STATUS_NOT_READY;
                end else begin
                    ctx       = dec_order ? int'(dec_prev) % CONTEXTS : 0;
                    low       = dec_state & mask;
                    s         = sym_at_slot[ctx * CTX_SLOTS + int'(low)];
                    f         = 32'(freq_of[ctx * 256 + int'(s)]);
                    c         = 32'(cum_of[ctx * 256 + int'(s)]);
                    dec_state = f * (dec_state >> lr) + low - c;
                    dec_prev  = s;
                    r.symbol_out = s;
                end
            end
            CMD_BYTE: begin
                if (dec_live && dec_state < BYTE_FLOOR) begin
                    dec_state = {dec_state[23:0], w.byte_in};
                end else begin
                    r.status = STATUS_NO_BYTE;
                end
            end
            default: begin
            end
        endcase
        r.need_byte = dec_live && dec_state < BYTE_FLOOR;
        return r;
    endfunction

    // A word with every field but the command random; the caller sets the command and what matters.
    function automatic cmd_word_t random_word();
        cmd_word_t w;
        w.command     = CMD_LOAD_SYM;
        w.context_req = 8'($urandom_range(255));
        w.symbol      = 8'($urandom_range(255));
        w.slot        = 12'($urandom_range(4095));
        w.cum_freq    = 12'($urandom_range(4095));
        w.freq        = 13'($urandom_range(1, 4096));
        w.init_state  = $urandom();
        w.byte_in     = 8'($urandom_range(255));
        return w;
    endfunction

    // Offer one word after a random gap, wait for the handshake, then book its result.
    task automatic push_word(input cmd_word_t w, input bit typed, input result_t given);
        result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        r = rans_advance(w);
        rans_out_q.push_back(typed ? given : r);
        words_sent++;
    endtask

    // Stop offering words until every booked result has come back.
    task automatic wait_results_in();
        s_tvalid <= 1'b0;
        while (rans_out_q.size() != 0) @(posedge aclk);
    endtask

    // Write both registers while the decoder is idle.
    task automatic write_cfg(input logic ord, input logic [3:0] lr);
        wait_results_in();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_ORDER;
        cfg_wdata <= LR_W'(ord);
        @(posedge aclk);
        cfg_addr  <= CFG_LOG_RANGE;
        cfg_wdata <= lr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dec_order = ord;
        dec_lr    = lr;
    endtask

    // Load whatever table entries the next decode reads and that were never written.
    task automatic fill_decode_path();
        cmd_word_t   w;
        int          ctx;
        int          skey;
        logic [31:0] low;
        ctx = dec_order ? int'(dec_prev) % CONTEXTS : 0;
        low = dec_state & live_mask();
        if (!sym_at_slot.exists(ctx * CTX_SLOTS + int'(low))) begin
            w             = random_word();
            w.command     = CMD_LOAD_SLOT;
            w.context_req = 8'(ctx);
            // Bits above the log range are ignored by the decoder.
            w.slot        = 12'(low | ($urandom() & ~live_mask()));
            push_word(w, 1'b0, '0);
        end
        skey = ctx * 256 + int'(sym_at_slot[ctx * CTX_SLOTS + int'(low)]);
        if (!cum_of.exists(skey)) begin
            w             = random_word();
            w.command     = CMD_LOAD_SYM;
            w.context_req = 8'(ctx);
            w.symbol      = sym_at_slot[ctx * CTX_SLOTS + int'(low)];
            push_word(w, 1'b0, '0);
        end
    endtask

    // Random chunks: start, decodes with the bytes they call for, and some misplaced commands.
    task automatic run_chunks(input int count, input bit pause_mid, input bit hold_mid);
        cmd_word_t w;
        int        stop_at;
        int        mid;
        int        pick;
        bit        mid_done;
        stop_at  = words_sent + count;
        mid      = words_sent + count / 2;
        mid_done = 1'b0;
        while (words_sent < stop_at) begin
            if (!mid_done && words_sent >= mid) begin
                mid_done = 1'b1;
                if (pause_mid) wait_results_in();
                if (hold_mid) hold_asks++;
            end
            w    = random_word();
            pick = $urandom_range(99);
            if (!dec_live || pick < 4) begin
                w.command = CMD_START;
                case ($urandom_range(9))
                    0: w.init_state = '0;
                    1: w.init_state = '1;
                    2: w.init_state = $urandom_range(32'h007F_FFFF);
                    default: ;
                endcase
            end else if (dec_state < BYTE_FLOOR) begin
                if (pick < 90) w.command = CMD_BYTE;
                else if (pick < 95) w.command = CMD_DECODE;
                else w.command = $urandom_range(1) ? CMD_LOAD_SYM : CMD_LOAD_SLOT;
            end else begin
                if (pick < 75) begin
                    fill_decode_path();
                    w.command = CMD_DECODE;
                end else if (pick < 85) begin
                    w.command = CMD_BYTE;
                end else begin
                    w.command = $urandom_range(1) ? CMD_LOAD_SYM : CMD_LOAD_SLOT;
                end
            end
            push_word(w, 1'b0, '0);
        end
    endtask

    // Receiver: random ready, or a long hold-off when one is asked for.
    always @(posedge aclk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result word with the oldest booked one.
    always @(posedge aclk) begin : check_out
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[10:0]);
            if (rans_out_q.size() == 0) begin
                $error("result word %h with no command outstanding", m_tdata);
                mismatches++;
            end else begin
                want = rans_out_q.pop_front();
                if (got.symbol_out !== want.symbol_out) begin
                    $error("symbol_out: expected %0h, got %0h", want.symbol_out, got.symbol_out);
                    mismatches++;
                end
                if (got.need_byte !== want.need_byte) begin
                    $error("need_byte: expected %0b, got %0b", want.need_byte, got.need_byte);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cmd_word_t w;
        result_t   given;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table under the first idling mix.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_cfg(dir_rows[i].context_req[0], dir_rows[i].symbol[3:0]);
            end else begin
                w.command          = dir_rows[i].command;
                w.context_req      = dir_rows[i].context_req;
                w.symbol           = dir_rows[i].symbol;
                w.slot             = dir_rows[i].slot;
                w.cum_freq         = dir_rows[i].cum_freq;
                w.freq             = dir_rows[i].freq;
                w.init_state       = dir_rows[i].init_state;
                w.byte_in          = dir_rows[i].byte_in;
                given.symbol_out   = dir_rows[i].symbol_out;
                given.need_byte    = dir_rows[i].need_byte;
                given.status       = dir_rows[i].status;
                push_word(w, dir_rows[i].typed, given);
            end
        end

        // Random phases, each with its own settings and idling mix.
        foreach (phases[p]) begin
            write_cfg(phases[p].order, phases[p].lr);
            send_idle_pct = phases[p].send_pct;
            recv_idle_pct = phases[p].recv_pct;
            run_chunks(PHASE_WORDS, phases[p].pause_mid, phases[p].hold_mid);
        end

        wait_results_in();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (rans_out_q.size() != 0) begin
            $error("%0d result words never arrived", rans_out_q.size());
        end
        if (mismatches == 0 && rans_out_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
